/* rtl/salc_pkg.sv */
// ----------------------------------------------------------------------------
// salc_pkg
// Shared widths and register indexes for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package salc_pkg;

  // configuration register file
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_OFFSET_BITS = 2'd2;

  localparam int SET_BITS_W  = 4;
  localparam int WAYS_CFG_W  = 4;
  localparam int OFFSET_W    = 5;

  localparam logic [SET_BITS_W-1:0] SET_BITS_RESET = 4'd4;
  localparam logic [WAYS_CFG_W-1:0] WAYS_RESET     = 4'd1;
  localparam logic [OFFSET_W-1:0]   OFFSET_RESET   = 5'd4;

  // recency rank: 0 is most recently used, saturates at the top code
  localparam int RANK_W = 3;
  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

  // running totals
  localparam int TOTAL_W = 32;

  // result word: hit, miss, eviction, three totals
  localparam int RES_W     = 3 + 3 * TOTAL_W;
  localparam int RES_BYTES = (RES_W + 7) / 8;
  localparam int OUT_DATA_W = RES_BYTES * 8;

endpackage

/* rtl/set_associative_lru_cache_model_top.sv */
// ----------------------------------------------------------------------------
// set_associative_lru_cache_model_top
// Tag store of a set-associative cache with LRU replacement and hit, miss
// and eviction counting.
// ----------------------------------------------------------------------------
// Each access word carries a byte address (tdata) and a modify flag (tuser).
// The address is split into offset, set and tag by the configured bit counts;
// the set's row (valid, rank and tag of every way) is read from one
// synchronous memory, updated and written back. A plain access passes through
// accept, row read, and lookup with write-back; a modify access makes a second
// pass, since its second lookup re-reads the row it just wrote. A lookup waits
// while the output register holds a result that has not been taken.
// A result waits in an output register while the next access is accepted.
// Any write to a mapped configuration register invalidates all lines at once
// through one valid flop per set row, so there is no clearing pass; totals are kept.
module set_associative_lru_cache_model_top
  import salc_pkg::*;
#(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [CFG_DATA_W-1:0]              cfg_data,
  // access stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [((ADDRESS_BITS+7)/8)*8-1:0]  s_axis_tdata,  // address, zero pad
  input  logic                               s_axis_tuser,  // func (1 = modify)
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // hit, miss, eviction, hit_total, miss_total, eviction_total, zero pad
  output logic [OUT_DATA_W-1:0]              m_axis_tdata,
  output logic                               m_axis_tlast   // last_of_run
);

  localparam int SETS      = 1 << MAX_SET_BITS;
  localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
  localparam int LINE_W    = 1 + RANK_W + ADDRESS_BITS;
  localparam int SHIFT_W   = 7;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOOK = 2'd2;

  // line layout: {valid, rank, tag}
  typedef logic [MAX_WAYS-1:0][LINE_W-1:0] row_t;

  // configuration registers
  logic [SET_BITS_W-1:0] set_index_bits;
  logic [WAYS_CFG_W-1:0] ways_in_use;
  logic [OFFSET_W-1:0]   block_offset_bits;
  logic                  cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == REG_SET_INDEX_BITS ||
                              cfg_index == REG_WAYS_IN_USE ||
                              cfg_index == REG_BLOCK_OFFSET_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits    <= SET_BITS_RESET;
      ways_in_use       <= WAYS_RESET;
      block_offset_bits <= OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SET_INDEX_BITS:    set_index_bits    <= cfg_data[SET_BITS_W-1:0];
        REG_WAYS_IN_USE:       ways_in_use       <= cfg_data[WAYS_CFG_W-1:0];
        REG_BLOCK_OFFSET_BITS: block_offset_bits <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // effective set bits and way count
  logic [SET_BITS_W-1:0] sbits;
  logic [WAY_CNT_W-1:0]  ways;

  always_comb begin
    if (32'(set_index_bits) > MAX_SET_BITS) sbits = SET_BITS_W'(MAX_SET_BITS);
    else                                    sbits = set_index_bits;
    if (ways_in_use == '0)                  ways = WAY_CNT_W'(1);
    else if (32'(ways_in_use) > MAX_WAYS)   ways = WAY_CNT_W'(MAX_WAYS);
    else                                    ways = WAY_CNT_W'(ways_in_use);
  end

  // address split at accept
  logic [ADDRESS_BITS-1:0] addr;
  logic [ADDRESS_BITS-1:0] set_field;
  logic [SHIFT_W-1:0]      shift;
  logic [SET_W-1:0]        set_d;
  logic [ADDRESS_BITS-1:0] tag_d;

  assign addr      = s_axis_tdata[ADDRESS_BITS-1:0];
  assign set_field = (addr >> block_offset_bits) & ~({ADDRESS_BITS{1'b1}} << sbits);
  assign set_d     = set_field[SET_W-1:0];
  assign shift     = SHIFT_W'(sbits) + SHIFT_W'(block_offset_bits);
  assign tag_d     = (32'(shift) >= ADDRESS_BITS) ? '0 : (addr >> shift);

  // control
  logic [1:0]              state;
  logic                    modify;
  logic                    pass;
  logic [SET_W-1:0]        set_q;
  logic [ADDRESS_BITS-1:0] tag_q;
  logic                    in_fire;
  logic                    look_fire;

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign look_fire     = (state == S_LOOK) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_fire) begin
          state <= S_READ;
          pass  <= 1'b0;
        end
        S_READ: state <= S_LOOK;
        S_LOOK: if (look_fire) begin
          if (modify && !pass) begin
            state <= S_READ;
            pass  <= 1'b1;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      modify <= s_axis_tuser;
      set_q  <= set_d;
      tag_q  <= tag_d;
    end
  end

  // row memory and per-row valid flops
  row_t             mem [SETS];
  logic [SETS-1:0]  row_ok;
  row_t             rd_row;
  logic             rd_ok;
  row_t             wr_row;

  always_ff @(posedge clk) begin
    if (state == S_READ) rd_row <= mem[set_q];
    if (look_fire)       mem[set_q] <= wr_row;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      row_ok <= '0;
    end else if (look_fire) begin
      row_ok[set_q] <= 1'b1;
    end
    if (state == S_READ) rd_ok <= row_ok[set_q];
  end

  // lookup, victim choice and rank update
  row_t                  cur;
  logic [MAX_WAYS-1:0]   v;
  logic [RANK_W-1:0]     rk [MAX_WAYS];
  logic                  found;
  logic                  inv_found;
  logic                  evict;
  logic [WAY_IDX_W-1:0]  target;
  logic [RANK_W:0]       old_rank;
  logic [RANK_W-1:0]     best_rank;
  logic [WAY_IDX_W-1:0]  best;

  always_comb begin
    cur       = rd_ok ? rd_row : '0;
    found     = 1'b0;
    inv_found = 1'b0;
    target    = '0;
    old_rank  = {1'b1, {RANK_W{1'b0}}};
    best      = '0;
    best_rank = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      v[w]  = cur[w][LINE_W-1];
      rk[w] = cur[w][ADDRESS_BITS +: RANK_W];
    end
    // tag match
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_CNT_W'(w) < ways && v[w] && cur[w][ADDRESS_BITS-1:0] == tag_q && !found) begin
        found    = 1'b1;
        target   = WAY_IDX_W'(w);
        old_rank = {1'b0, rk[w]};
      end
    end
    // first free way
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!found && WAY_CNT_W'(w) < ways && !v[w] && !inv_found) begin
        inv_found = 1'b1;
        target    = WAY_IDX_W'(w);
      end
    end
    // oldest way, lowest index on a tie
    best_rank = rk[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (WAY_CNT_W'(w) < ways && rk[w] > best_rank) begin
        best      = WAY_IDX_W'(w);
        best_rank = rk[w];
      end
    end
    evict = !found && !inv_found;
    if (evict) begin
      target   = best;
      old_rank = {1'b0, best_rank};
    end
    // age the others, refill the target
    wr_row = cur;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_CNT_W'(w) < ways) begin
        if (WAY_IDX_W'(w) == target) begin
          wr_row[w] = {1'b1, {RANK_W{1'b0}}, tag_q};
        end else if (v[w] && {1'b0, rk[w]} < old_rank && rk[w] < RANK_MAX) begin
          wr_row[w][ADDRESS_BITS +: RANK_W] = rk[w] + RANK_W'(1);
        end
      end
    end
  end

  // totals and output register
  logic [TOTAL_W-1:0] hit_total;
  logic [TOTAL_W-1:0] miss_total;
  logic [TOTAL_W-1:0] eviction_total;
  logic               out_hit;
  logic               out_miss;
  logic               out_evict;
  logic               out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid  <= 1'b0;
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
    end else begin
      if (look_fire) begin
        m_axis_tvalid <= 1'b1;
        if (found && hit_total != '1)       hit_total      <= hit_total + 1'b1;
        if (!found && miss_total != '1)     miss_total     <= miss_total + 1'b1;
        if (evict && eviction_total != '1)  eviction_total <= eviction_total + 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (look_fire) begin
      out_hit   <= found;
      out_miss  <= !found;
      out_evict <= evict;
      out_last  <= !modify || pass;
    end
  end

  assign m_axis_tdata = {{(OUT_DATA_W - RES_W){1'b0}}, eviction_total, miss_total,
                         hit_total, out_evict, out_miss, out_hit};
  assign m_axis_tlast = out_last;

endmodule

/* bench/lru_tag_checker.sv */
// ----------------------------------------------------------------------------
// lru_tag_checker
// Watches the access, result and configuration channels of the cache model,
// keeps its own copy of the tag store and compares every result word.
// ----------------------------------------------------------------------------
module lru_tag_checker
  import salc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  acc_valid,
  input  logic                  acc_ready,
  input  logic [31:0]           acc_addr,
  input  logic                  acc_modify,
  input  logic                  res_valid,
  input  logic                  res_ready,
  input  logic [OUT_DATA_W-1:0] res_data,
  input  logic                  res_last,
  output int                    error_count,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_LIMIT = 8;
  localparam int WAY_LIMIT = 8;
  localparam int SET_COUNT = 1 << SET_LIMIT;
  localparam int HITS_LSB   = 3;
  localparam int MISSES_LSB = 3 + TOTAL_W;
  localparam int EVICTS_LSB = 3 + 2 * TOTAL_W;

  typedef struct {
    logic               hit;
    logic               miss;
    logic               evict;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] misses;
    logic [TOTAL_W-1:0] evicts;
    logic               last;
  } outcome_t;

  outcome_t expected_outcomes[$];

  // mirrored tag store and totals
  logic                  line_ok   [SET_COUNT][WAY_LIMIT];
  logic [31:0]           line_tags [SET_COUNT][WAY_LIMIT];
  logic [RANK_W-1:0]     line_rank [SET_COUNT][WAY_LIMIT];
  logic [TOTAL_W-1:0]    hit_cnt, miss_cnt, evict_cnt;
  logic [SET_BITS_W-1:0] set_bits_r;
  logic [WAYS_CFG_W-1:0] ways_r;
  logic [OFFSET_W-1:0]   offset_r;
  int                    errs = 0;

  function automatic void invalidate_all();
    for (int s = 0; s < SET_COUNT; s++) begin
      for (int w = 0; w < WAY_LIMIT; w++) begin
        line_ok[s][w]   = 1'b0;
        line_rank[s][w] = '0;
      end
    end
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_inc(logic [TOTAL_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // one lookup in one set: hit, fill of the first free way, or LRU refill
  function automatic void predict_lookup(input int s, input logic [31:0] tag,
                                         input int ways, output outcome_t o);
    int target;
    int old_rank;
    int best;
    o = '{default: '0};
    target   = ways;
    old_rank = 8;
    for (int w = 0; w < ways; w++) begin
      if (line_ok[s][w] && line_tags[s][w] == tag) begin
        target   = w;
        old_rank = line_rank[s][w];
        o.hit    = 1'b1;
        break;
      end
    end
    if (target == ways) begin
      for (int w = 0; w < ways; w++) begin
        if (!line_ok[s][w]) begin
          target = w;
          break;
        end
      end
      o.miss = 1'b1;
    end
    if (target == ways) begin
      best = 0;
      for (int w = 1; w < ways; w++) begin
        if (line_rank[s][w] > line_rank[s][best]) best = w;
      end
      target   = best;
      old_rank = line_rank[s][best];
      o.evict  = 1'b1;
    end
    // age the valid ways that were more recent than the touched one
    for (int w = 0; w < ways; w++) begin
      if (w != target && line_ok[s][w] && line_rank[s][w] < old_rank &&
          line_rank[s][w] < RANK_MAX)
        line_rank[s][w] = line_rank[s][w] + 1'b1;
    end
    line_ok[s][target]   = 1'b1;
    line_tags[s][target] = tag;
    line_rank[s][target] = '0;
    if (o.hit)   hit_cnt   = sat_inc(hit_cnt);
    if (o.miss)  miss_cnt  = sat_inc(miss_cnt);
    if (o.evict) evict_cnt = sat_inc(evict_cnt);
    o.hits   = hit_cnt;
    o.misses = miss_cnt;
    o.evicts = evict_cnt;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin : watch
    int        sbe;
    int        ways;
    int        shift;
    int        set_n;
    int        n;
    logic [31:0] tag;
    outcome_t  o;
    outcome_t  want;
    if (rst) begin
      expected_outcomes.delete();
      invalidate_all();
      hit_cnt    = '0;
      miss_cnt   = '0;
      evict_cnt  = '0;
      set_bits_r = SET_BITS_RESET;
      ways_r     = WAYS_RESET;
      offset_r   = OFFSET_RESET;
    end else begin
      // register write; an unmapped index changes nothing
      if (cfg_we) begin
        case (cfg_index)
          REG_SET_INDEX_BITS: begin
            set_bits_r = cfg_data[SET_BITS_W-1:0];
            invalidate_all();
          end
          REG_WAYS_IN_USE: begin
            ways_r = cfg_data[WAYS_CFG_W-1:0];
            invalidate_all();
          end
          REG_BLOCK_OFFSET_BITS: begin
            offset_r = cfg_data[OFFSET_W-1:0];
            invalidate_all();
          end
          default: ;
        endcase
      end

      // result word against the oldest expectation
      if (res_valid && res_ready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result word with no access pending: %h last %b", res_data, res_last);
          errs++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("hit", want.hit, res_data[0]);
          check_field("miss", want.miss, res_data[1]);
          check_field("eviction", want.evict, res_data[2]);
          check_field("hit_total", want.hits, res_data[HITS_LSB +: TOTAL_W]);
          check_field("miss_total", want.misses, res_data[MISSES_LSB +: TOTAL_W]);
          check_field("eviction_total", want.evicts, res_data[EVICTS_LSB +: TOTAL_W]);
          check_field("last_of_run", want.last, res_last);
        end
      end

      // accepted access: split the address and run one or two lookups
      if (acc_valid && acc_ready) begin
        sbe   = (set_bits_r > SET_LIMIT) ? SET_LIMIT : set_bits_r;
        ways  = (ways_r == 0) ? 1 : (ways_r > WAY_LIMIT) ? WAY_LIMIT : ways_r;
        shift = sbe + offset_r;
        set_n = int'((acc_addr >> offset_r) & ((32'd1 << sbe) - 1));
        tag   = (shift >= 32) ? 32'd0 : (acc_addr >> shift);
        n     = acc_modify ? 2 : 1;
        for (int k = 0; k < n; k++) begin
          predict_lookup(set_n, tag, ways, o);
          o.last = (k == n - 1);
          expected_outcomes.push_back(o);
        end
      end
    end
    error_count <= errs;
    outstanding <= expected_outcomes.size();
  end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the set-associative LRU cache model.
// Directed accesses over the corner configurations, then random phases that
// reconfigure the cache and hammer a small pool of conflicting blocks, with
// random idle bursts on both streams. Checking is done in lru_tag_checker.
// ----------------------------------------------------------------------------
module tb
  import salc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODIFY = 1'b1;
  localparam logic PLAIN  = 1'b0;
  localparam int   PHASES = 12;
  localparam int   PHASE_WORDS = 50;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  int errors;
  int pending;

  // stall control
  logic send_gaps = 1'b0;
  logic sink_stalls = 1'b0;
  int   stall_left = 0;

  // configuration as last written, for building addresses
  logic [SET_BITS_W-1:0] mir_sets = SET_BITS_RESET;
  logic [WAYS_CFG_W-1:0] mir_ways = WAYS_RESET;
  logic [OFFSET_W-1:0]   mir_offset = OFFSET_RESET;

  set_associative_lru_cache_model_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  lru_tag_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .acc_valid   (s_axis_tvalid),
    .acc_ready   (s_axis_tready),
    .acc_addr    (s_axis_tdata),
    .acc_modify  (s_axis_tuser),
    .res_valid   (m_axis_tvalid),
    .res_ready   (m_axis_tready),
    .res_data    (m_axis_tdata),
    .res_last    (m_axis_tlast),
    .error_count (errors),
    .outstanding (pending)
  );

  always #4 clk = ~clk;

  // result side: random stall bursts on tready
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 4);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // offer one access word, maybe after an idle burst, and wait for accept
  task automatic send_access(input logic func, input logic [31:0] addr);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= func;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // wait until every expected result word has come back
  task automatic drain();
    int guard;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < 5000);
  endtask

  // write the selected registers back to back; sel bit i is register index i
  task automatic program_cache(input logic [3:0] sel, input logic [4:0] sets_v,
                               input logic [4:0] ways_v, input logic [4:0] off_v,
                               input logic [4:0] junk_v);
    logic [CFG_IDX_W-1:0] idx;
    logic [4:0]           val;
    for (int i = 0; i < 4; i++) begin
      if (sel[i]) begin
        idx = CFG_IDX_W'(i);
        case (idx)
          REG_SET_INDEX_BITS: begin
            val = sets_v;
            mir_sets = sets_v[SET_BITS_W-1:0];
          end
          REG_WAYS_IN_USE: begin
            val = ways_v;
            mir_ways = ways_v[WAYS_CFG_W-1:0];
          end
          REG_BLOCK_OFFSET_BITS: begin
            val = off_v;
            mir_offset = off_v;
          end
          default: val = junk_v;
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  // address for a given tag and set under the current split
  function automatic logic [31:0] make_addr(input int tag, input int setn,
                                            input logic [31:0] off);
    int          sbe;
    logic [63:0] a;
    sbe = (mir_sets > 8) ? 8 : mir_sets;
    a = (64'(tag) << (sbe + mir_offset)) |
        ((64'(setn) & ((64'd1 << sbe) - 1)) << mir_offset) |
        (64'(off) & ((64'd1 << mir_offset) - 1));
    return a[31:0];
  endfunction

  initial begin
    int          pool_tag [12];
    int          pool_set [12];
    int          pool_n;
    int          eff_ways;
    int          k;
    logic [3:0]  sel;
    logic [4:0]  v_sets, v_ways, v_off;
    logic [31:0] a;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset split: 4 set bits, one way, 4 offset bits
    send_access(PLAIN, 32'h0000_0000);
    send_access(PLAIN, 32'h0000_000F);
    send_access(PLAIN, 32'hFFFF_FFFF);
    send_access(MODIFY, 32'h0000_0010);
    send_access(PLAIN, 32'h0000_0100);
    s_axis_tvalid <= 1'b0;
    drain();

    // two ways, LRU order within set 0
    program_cache(4'b0111, 5'd2, 5'd2, 5'd2, 5'd0);
    send_access(PLAIN, 32'h0000_0000);
    send_access(PLAIN, 32'h0000_0010);
    send_access(PLAIN, 32'h0000_0000);
    send_access(PLAIN, 32'h0000_0020);
    send_access(PLAIN, 32'h0000_0010);
    send_access(MODIFY, 32'h0000_0020);
    s_axis_tvalid <= 1'b0;
    drain();

    // zero ways behaves as one
    program_cache(4'b0010, 5'd0, 5'd0, 5'd0, 5'd0);
    send_access(PLAIN, 32'h0000_0000);
    send_access(PLAIN, 32'h0000_0010);
    s_axis_tvalid <= 1'b0;
    drain();

    // oversized set count and way count, no tag bits left
    program_cache(4'b0111, 5'h1F, 5'd15, 5'd31, 5'd0);
    send_access(PLAIN, 32'h8000_0000);
    send_access(PLAIN, 32'h0000_0000);
    send_access(PLAIN, 32'hFFFF_FFFF);
    s_axis_tvalid <= 1'b0;
    drain();

    // unmapped index must leave the lines alone
    program_cache(4'b1000, 5'd0, 5'd0, 5'd0, 5'h1F);
    send_access(PLAIN, 32'h7FFF_FFFF);
    s_axis_tvalid <= 1'b0;
    drain();

    // single set, full-address tag, eight ways
    program_cache(4'b0111, 5'd0, 5'd8, 5'd0, 5'd0);
    send_access(PLAIN, 32'h1234_5678);
    send_access(MODIFY, 32'h1234_5678);
    send_access(PLAIN, 32'hFFFF_FFFF);
    send_access(PLAIN, 32'h1234_5679);
    s_axis_tvalid <= 1'b0;
    drain();

    // random phases: new split, then a small pool of conflicting blocks
    for (int p = 0; p < PHASES; p++) begin
      sel = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15))
                                         : {1'($urandom_range(0, 1)), 3'b111};
      v_sets = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 4));
      v_ways = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(1, 8));
      v_off  = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 6));
      program_cache(sel, v_sets, v_ways, v_off, 5'($urandom));

      eff_ways = (mir_ways == 0) ? 1 : (mir_ways > 8) ? 8 : mir_ways;
      pool_n = eff_ways + $urandom_range(0, 2);
      for (int j = 0; j < pool_n; j++) begin
        pool_tag[j] = $urandom_range(0, 15);
        pool_set[j] = $urandom_range(0, 1);
      end

      // no idling in the last phases
      send_gaps   = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
      sink_stalls <= (p < PHASES - 2) && ($urandom_range(0, 3) != 0);

      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          a = $urandom;
        end else begin
          k = $urandom_range(0, pool_n - 1);
          a = make_addr(pool_tag[k], pool_set[k], $urandom);
        end
        send_access($urandom_range(0, 3) == 0, a);
      end
      s_axis_tvalid <= 1'b0;
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
